// ===== rtl/utf8dec_pkg.sv =====
// shared types, constants and a helper of the utf-8 decoder
package utf8dec_pkg;

	localparam logic [20:0] REPL_CP    = 21'h00FFFD;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] MIN_TWO    = 21'h000080;
	localparam logic [20:0] MIN_THREE  = 21'h000800;
	localparam logic [20:0] MIN_FOUR   = 21'h010000;

	localparam int unsigned CAP_W      = 16;
	localparam int unsigned CP_W       = 21;
	localparam int unsigned RCOUNT_W   = 16;
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned OUT_USER_W = 3;

	// tuser bit positions on the master side
	localparam int unsigned USER_REPLACED = 0;
	localparam int unsigned USER_OVERFLOW = 1;
	localparam int unsigned USER_RUN_LAST = 2;

	// one decoded byte: replacements to send, then an optional final result
	typedef struct packed {
		logic [2:0]      left;
		logic            has_final;
		logic [CP_W-1:0] fin_cp;
		logic            fin_repl;
		logic            last;
	} bundle_t;

	// continuation bytes a lead byte asks for, zero when it is no lead
	function automatic logic [1:0] lead_need(input logic [7:0] b);
		logic [1:0] n;
		n = 2'd0;
		if ((b & 8'hE0) == 8'hC0) n = 2'd1;
		else if ((b & 8'hF0) == 8'hE0) n = 2'd2;
		else if ((b & 8'hF8) == 8'hF0) n = 2'd3;
		return n;
	endfunction

endpackage

// ===== rtl/utf8dec_decode.sv =====
// sequence state and per-byte decode into a result bundle
module utf8dec_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           byte_in,
	input  logic                 string_last,
	output utf8dec_pkg::bundle_t bundle
);
	import utf8dec_pkg::*;

	logic [7:0]      lead_q;
	logic            active_q;
	logic [1:0]      cont_q;
	logic [CP_W-1:0] part_q;

	logic [7:0]      nxt_lead;
	logic            nxt_active;
	logic [1:0]      nxt_cont;
	logic [CP_W-1:0] nxt_part;

	logic [1:0]      need_q;
	logic [1:0]      need_b;
	logic [1:0]      cont_inc;
	logic [CP_W-1:0] part_shift;
	logic [1:0]      n_rep;
	logic            has_final;
	logic [CP_W-1:0] fin_cp;
	logic            fin_repl;
	logic            handled;
	logic            bad;

	// lead lengths and the gathered value with this byte shifted in
	assign need_q     = lead_need(lead_q);
	assign need_b     = lead_need(byte_in);
	assign cont_inc   = cont_q + 2'd1;
	assign part_shift = {part_q[CP_W-7:0], byte_in[5:0]};

	// range checks on a completed sequence
	always_comb begin
		unique case (need_q)
			2'd1:    bad = part_shift < MIN_TWO;
			2'd2:    bad = (part_shift < MIN_THREE) ||
			               ((part_shift >= SURR_LO) && (part_shift <= SURR_HI));
			default: bad = (part_shift < MIN_FOUR) || (part_shift > CP_MAX);
		endcase
	end

	// next state and results for this byte
	always_comb begin
		nxt_lead   = lead_q;
		nxt_active = active_q;
		nxt_cont   = cont_q;
		nxt_part   = part_q;
		n_rep      = 2'd0;
		has_final  = 1'b0;
		fin_cp     = REPL_CP;
		fin_repl   = 1'b1;
		handled    = 1'b0;

		// open sequence: gather, finish or break
		if (active_q) begin
			if ((byte_in[7:6] == 2'b10) && (need_q != 2'd0)) begin
				handled  = 1'b1;
				nxt_cont = cont_inc;
				nxt_part = part_shift;
				if (cont_inc >= need_q) begin
					has_final = 1'b1;
					if (!bad) begin
						fin_cp   = part_shift;
						fin_repl = 1'b0;
					end
					nxt_active = 1'b0;
					nxt_cont   = 2'd0;
					nxt_part   = '0;
					nxt_lead   = 8'h00;
				end else if (string_last) begin
					n_rep = cont_inc + 2'd1;
				end
			end else begin
				n_rep      = cont_q + 2'd1;
				nxt_active = 1'b0;
				nxt_cont   = 2'd0;
				nxt_part   = '0;
				nxt_lead   = 8'h00;
			end
		end

		// fresh decode of the byte
		if (!handled) begin
			if (!byte_in[7]) begin
				has_final = 1'b1;
				fin_cp    = {13'd0, byte_in};
				fin_repl  = 1'b0;
			end else if ((need_b == 2'd0) || string_last) begin
				has_final = 1'b1;
			end else begin
				nxt_lead   = byte_in;
				nxt_active = 1'b1;
				nxt_cont   = 2'd0;
				unique case (need_b)
					2'd1:    nxt_part = {16'd0, byte_in[4:0]};
					2'd2:    nxt_part = {17'd0, byte_in[3:0]};
					default: nxt_part = {18'd0, byte_in[2:0]};
				endcase
			end
		end

		// end of string clears the sequence
		if (string_last) begin
			nxt_active = 1'b0;
			nxt_cont   = 2'd0;
			nxt_part   = '0;
			nxt_lead   = 8'h00;
		end
	end

	// bundle toward the emitter
	always_comb begin
		bundle.left      = {1'b0, n_rep} + {2'b00, has_final};
		bundle.has_final = has_final;
		bundle.fin_cp    = fin_cp;
		bundle.fin_repl  = fin_repl;
		bundle.last      = string_last;
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q   <= 8'h00;
			active_q <= 1'b0;
			cont_q   <= 2'd0;
			part_q   <= '0;
		end else if (accept) begin
			lead_q   <= nxt_lead;
			active_q <= nxt_active;
			cont_q   <= nxt_cont;
			part_q   <= nxt_part;
		end
	end

endmodule

// ===== rtl/utf8dec_emit.sv =====
// bundle register, result serializer, string counter and output register
module utf8dec_emit #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     load,
	input  utf8dec_pkg::bundle_t                     bundle_in,
	input  logic [utf8dec_pkg::CAP_W-1:0]            capacity,
	output logic                                     free,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [utf8dec_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic [utf8dec_pkg::OUT_USER_W-1:0]       m_tuser,
	output logic                                     m_tlast
);
	import utf8dec_pkg::*;

	localparam int unsigned CW = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

	bundle_t               bun_s1;
	logic                  bvalid_s1;
	logic                  ovalid_s2;
	logic [CP_W-1:0]       cp_s2;
	logic [RCOUNT_W-1:0]   rcount_s2;
	logic                  repl_s2;
	logic                  ovf_s2;
	logic                  run_last_s2;
	logic                  done_s2;

	logic [COUNT_BITS-1:0] count_q;
	logic                  ovf_q;

	logic                  out_load;
	logic                  is_final;
	logic                  run_end;
	logic                  item_done;
	logic                  cap_hit;
	logic                  ovf_n;
	logic [COUNT_BITS-1:0] cnt_n;
	logic [CW-1:0]         cnt_ext;
	logic [CP_W-1:0]       item_cp;
	logic                  item_repl;

	// handshake between bundle register and output register
	assign out_load  = bvalid_s1 && (!ovalid_s2 || m_tready);
	assign run_end   = (bun_s1.left == 3'd1);
	assign is_final  = run_end && bun_s1.has_final;
	assign item_done = run_end && bun_s1.last;
	assign free      = !bvalid_s1 || (out_load && run_end);

	// fields of the result now leaving the bundle
	assign item_cp   = is_final ? bun_s1.fin_cp : REPL_CP;
	assign item_repl = is_final ? bun_s1.fin_repl : 1'b1;

	// running count and sticky overflow
	assign cap_hit = (capacity != '0) && (CW'(count_q) >= CW'(capacity));
	assign ovf_n   = ovf_q || cap_hit;
	assign cnt_n   = (count_q == {COUNT_BITS{1'b1}}) ? count_q : count_q + 1'b1;
	assign cnt_ext = CW'(cnt_n);

	// bundle register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_s1 <= 1'b0;
			bun_s1    <= '0;
		end else if (load) begin
			bvalid_s1 <= 1'b1;
			bun_s1    <= bundle_in;
		end else if (out_load) begin
			if (run_end) begin
				bvalid_s1 <= 1'b0;
			end else begin
				bun_s1.left <= bun_s1.left - 3'd1;
			end
		end
	end

	// counter state per string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (out_load) begin
			if (item_done) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= cnt_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_s2 <= 1'b0;
		end else if (out_load) begin
			ovalid_s2 <= 1'b1;
		end else if (m_tready) begin
			ovalid_s2 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			cp_s2       <= item_cp;
			repl_s2     <= item_repl;
			rcount_s2   <= cnt_ext[RCOUNT_W-1:0];
			ovf_s2      <= ovf_n;
			run_last_s2 <= run_end;
			done_s2     <= item_done;
		end
	end

	assign m_tvalid = ovalid_s2;
	assign m_tdata  = {{(OUT_DATA_W - CP_W - RCOUNT_W){1'b0}}, rcount_s2, cp_s2};
	assign m_tuser  = {run_last_s2, ovf_s2, repl_s2};
	assign m_tlast  = done_s2;

endmodule

// ===== rtl/utf8_to_codepoint_decoder_unit.sv =====
// UTF-8 byte stream to code point decoder, top level
//
// Accepts one UTF-8 byte per cycle while s_tready is high, with tlast on the
// final byte of a string, and returns code points one per cycle while m_tready
// is high, U+FFFD for malformed input. A byte yields zero to four results: a
// lead byte that does not end the string yields none, a plain or completed
// character one, and a broken or cut-short sequence one U+FFFD for the lead
// and each gathered continuation ahead of the fresh decode of the breaking
// byte. The input is taken again in the cycle the last result of the previous
// byte moves from the bundle register into the single-result output register,
// so it waits while a byte's results leave. Each result carries its running
// count within the string (saturating at 2^COUNT_BITS-1) and a sticky overflow
// flag set once the count passes a nonzero capacity; both restart after the
// final result of a string. The user must write the capacity register through
// the cfg channel only while the block is idle; the block does not enforce this.
module utf8_to_codepoint_decoder_unit #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write: capacity
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [utf8dec_pkg::CAP_W-1:0]       cfg_data,
	// slave side
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [utf8dec_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] byte_in
	input  logic                                s_tlast,   // string_last
	// master side
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [utf8dec_pkg::OUT_DATA_W-1:0]  m_tdata,   // [20:0] code_point,
	                                                       // [36:21] result_count
	output logic [utf8dec_pkg::OUT_USER_W-1:0]  m_tuser,   // [0] replaced,
	                                                       // [1] overflow, [2] run_last
	output logic                                m_tlast    // string_done
);
	import utf8dec_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             accept;
	logic             load;
	logic             free;
	bundle_t          bundle;

	// capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// input transfer
	assign s_tready = free;
	assign accept   = s_tvalid && s_tready;
	assign load     = accept && (bundle.left != 3'd0);

	utf8dec_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.byte_in     (s_tdata),
		.string_last (s_tlast),
		.bundle      (bundle)
	);

	utf8dec_emit #(
		.COUNT_BITS (COUNT_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle_in (bundle),
		.capacity  (capacity_q),
		.free      (free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== rtl/utf8dec_checker.sv =====
// port-level checks of the utf-8 decoder and their bind
module utf8dec_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [utf8dec_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [utf8dec_pkg::OUT_USER_W-1:0]  m_tuser,
	input logic                                m_tlast
);
	import utf8dec_pkg::*;

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// the final result of a string is also the last of its byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[USER_RUN_LAST])
		else $error("string end without run end");

	// replacements always carry U+FFFD
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_REPLACED] |-> (m_tdata[CP_W-1:0] == REPL_CP))
		else $error("replacement with wrong code point");

	// decoded values are scalar values
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[USER_REPLACED] |->
			(m_tdata[CP_W-1:0] <= CP_MAX) &&
			((m_tdata[CP_W-1:0] < SURR_LO) || (m_tdata[CP_W-1:0] > SURR_HI)))
		else $error("code point out of range");

endmodule

bind utf8_to_codepoint_decoder_unit utf8dec_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
